// ===== hdl/pdll_pkg.sv =====
// shared opcodes, status codes and sequencer states for the pooled list unit
package pdll_pkg;

   localparam logic [2:0] OP_APPEND = 3'd0;
   localparam logic [2:0] OP_INSERT = 3'd1;
   localparam logic [2:0] OP_ERASE  = 3'd2;
   localparam logic [2:0] OP_CLEAR  = 3'd3;
   localparam logic [2:0] OP_READ   = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_NONODE = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_FETCH = 7'b0000010,
      S_EXEC  = 7'b0000100,
      S_LINK  = 7'b0001000,
      S_WALK  = 7'b0010000,
      S_WSTEP = 7'b0100000,
      S_INIT  = 7'b1000000
   } seq_state_type;

endpackage

// ===== hdl/pooled_doubly_linked_list_unit.sv =====
// pooled doubly linked list unit: link memories, free chain and request sequencer
// requests pass fetch, then exec (clear: walk); a successful insert or erase, or an append
// to a non-empty list, adds a link step; the walk reads each next link and frees its node
// one request at a time; busy stays high until the response strobe
// after reset an init pass links every node into the free chain; busy stays high
// results are shown for one cycle on rsp_valid; the receiver cannot stall
module pooled_doubly_linked_list_unit
   import pdll_pkg::*;
#(
   parameter int NODE_COUNT   = 64,
   parameter int ELEMENT_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [2:0]              req_op,
   input  logic [$clog2(NODE_COUNT+1)-1:0] req_node_index,
   input  logic [ELEMENT_BITS-1:0] req_element_in,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic [$clog2(NODE_COUNT+1)-1:0] rsp_created_node,
   output logic [ELEMENT_BITS-1:0] rsp_element_out,
   output logic [$clog2(NODE_COUNT+1)-1:0] rsp_node_count,
   output logic [$clog2(NODE_COUNT+1)-1:0] rsp_first_node,
   output logic [$clog2(NODE_COUNT+1)-1:0] rsp_last_node
);

   localparam int IW = $clog2(NODE_COUNT + 1);
   localparam int AW = $clog2(NODE_COUNT);
   localparam logic [IW-1:0] NONE = IW'(NODE_COUNT);

   // link and element memories
   logic [IW-1:0]           next_mem [NODE_COUNT];
   logic [IW-1:0]           prev_mem [NODE_COUNT];
   logic [ELEMENT_BITS-1:0] elem_mem [NODE_COUNT];
   logic [NODE_COUNT-1:0]   in_use_ff, in_use_in;

   seq_state_type state_ff, state_in;
   logic [IW-1:0] free_ff, free_in, head_ff, head_in, tail_ff, tail_in;
   logic [IW-1:0] count_ff, count_in, walk_ff, walk_in;
   logic [2:0]    op_ff, op_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [ELEMENT_BITS-1:0] elem_ff, elem_in;
   logic [IW-1:0] nrd_ff, prd_ff;
   logic [ELEMENT_BITS-1:0] erd_ff;
   logic [IW-1:0] save_ff, save_in;   // node index kept for the second step

   // memory port controls
   logic          nrd_en, nwr_en, pwr_en, ewr_en;
   logic [AW-1:0] nrd_a, nwr_a, prd_a, pwr_a, erd_a, ewr_a;
   logic [IW-1:0] nwr_d, pwr_d;

   logic          out_v_ff, out_v_in;
   logic [1:0]    out_st_ff, out_st_in;
   logic [IW-1:0] out_nn_ff, out_nn_in;
   logic [ELEMENT_BITS-1:0] out_el_ff, out_el_in;

   logic idx_ok, full, idx_used;
   assign idx_ok   = idx_ff < NONE;
   assign full     = (count_ff >= NONE) || (free_ff >= NONE);
   assign idx_used = idx_ok && in_use_ff[idx_ff[AW-1:0]];

   // synchronous memories, one write and one read port each
   always_ff @(posedge clock) begin
      if (nwr_en) next_mem[nwr_a] <= nwr_d;
      if (nrd_en) nrd_ff <= next_mem[nrd_a];
      if (pwr_en) prev_mem[pwr_a] <= pwr_d;
      prd_ff <= prev_mem[prd_a];
      if (ewr_en) elem_mem[ewr_a] <= elem_ff;
      erd_ff <= elem_mem[erd_a];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      free_in = free_ff; head_in = head_ff; tail_in = tail_ff;
      count_in = count_ff; walk_in = walk_ff; save_in = save_ff;
      op_in = op_ff; idx_in = idx_ff; elem_in = elem_ff;
      in_use_in = in_use_ff;
      nrd_en = 1'b0; nwr_en = 1'b0; pwr_en = 1'b0; ewr_en = 1'b0;
      nrd_a = free_ff[AW-1:0]; nwr_a = '0; nwr_d = '0;
      prd_a = idx_ff[AW-1:0]; pwr_a = '0; pwr_d = '0;
      erd_a = idx_ff[AW-1:0]; ewr_a = free_ff[AW-1:0];
      out_v_in = 1'b0; out_st_in = ST_OK; out_nn_in = NONE; out_el_in = '0;
      case (state_ff)
         S_INIT: begin
            // build the free chain in index order
            nwr_en = 1'b1;
            nwr_a  = walk_ff[AW-1:0];
            nwr_d  = walk_ff + IW'(1);
            walk_in = walk_ff + IW'(1);
            if (walk_ff == NONE - IW'(1)) begin
               walk_in  = NONE;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               op_in = req_op; idx_in = req_node_index; elem_in = req_element_in;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            // read free-chain successor or the target's next link
            nrd_en = 1'b1;
            nrd_a  = (op_ff == OP_ERASE) ? idx_ff[AW-1:0] : free_ff[AW-1:0];
            state_in = (op_ff == OP_CLEAR) ? S_WALK : S_EXEC;
            walk_in  = head_ff;
         end
         S_EXEC: begin
            state_in = S_IDLE;
            out_v_in = 1'b1;
            case (op_ff)
               OP_APPEND: begin
                  if (full) out_st_in = ST_FULL;
                  else begin
                     free_in = nrd_ff;
                     in_use_in[free_ff[AW-1:0]] = 1'b1;
                     ewr_en = 1'b1;
                     pwr_en = 1'b1; pwr_a = free_ff[AW-1:0]; pwr_d = tail_ff;
                     nwr_en = 1'b1; nwr_a = free_ff[AW-1:0]; nwr_d = NONE;
                     count_in = count_ff + IW'(1);
                     tail_in  = free_ff;
                     out_nn_in = free_ff;
                     if (tail_ff >= NONE) head_in = free_ff;
                     else begin
                        save_in = free_ff; idx_in = tail_ff;
                        out_v_in = 1'b0; state_in = S_LINK;
                     end
                  end
               end
               OP_INSERT: begin
                  if (!idx_ok) out_st_in = ST_NONODE;
                  else if (full) out_st_in = ST_FULL;
                  else if (!idx_used) out_st_in = ST_NONODE;
                  else begin
                     free_in = nrd_ff;
                     in_use_in[free_ff[AW-1:0]] = 1'b1;
                     ewr_en = 1'b1;
                     pwr_en = 1'b1; pwr_a = idx_ff[AW-1:0]; pwr_d = free_ff;
                     nwr_en = 1'b1; nwr_a = free_ff[AW-1:0]; nwr_d = idx_ff;
                     count_in = count_ff + IW'(1);
                     out_nn_in = free_ff;
                     save_in = free_ff;
                     // second step writes new node's prev and p's next
                     idx_in = prd_ff; out_v_in = 1'b0; state_in = S_LINK;
                  end
               end
               OP_ERASE: begin
                  if (!idx_ok) out_st_in = ST_NONODE;
                  else if (count_ff == '0) out_st_in = ST_EMPTY;
                  else if (!idx_used) out_st_in = ST_NONODE;
                  else begin
                     in_use_in[idx_ff[AW-1:0]] = 1'b0;
                     count_in = count_ff - IW'(1);
                     if (prd_ff < NONE) begin
                        nwr_en = 1'b1; nwr_a = prd_ff[AW-1:0]; nwr_d = nrd_ff;
                     end else head_in = nrd_ff;
                     if (nrd_ff < NONE) begin
                        pwr_en = 1'b1; pwr_a = nrd_ff[AW-1:0]; pwr_d = prd_ff;
                     end else tail_in = prd_ff;
                     save_in = idx_ff;
                     out_v_in = 1'b0; state_in = S_LINK;
                  end
               end
               OP_READ: begin
                  if (!idx_ok) out_st_in = ST_NONODE;
                  else if (count_ff == '0) out_st_in = ST_EMPTY;
                  else if (!idx_used) out_st_in = ST_NONODE;
                  else out_el_in = erd_ff;
               end
               default: ;
            endcase
         end
         S_LINK: begin
            state_in = S_IDLE;
            out_v_in = 1'b1;
            out_nn_in = (op_ff == OP_ERASE) ? NONE : save_ff;
            case (op_ff)
               OP_APPEND: begin
                  nwr_en = 1'b1; nwr_a = idx_ff[AW-1:0]; nwr_d = save_ff;
               end
               OP_INSERT: begin
                  pwr_en = 1'b1; pwr_a = save_ff[AW-1:0]; pwr_d = idx_ff;
                  if (idx_ff < NONE) begin
                     nwr_en = 1'b1; nwr_a = idx_ff[AW-1:0]; nwr_d = save_ff;
                  end else head_in = save_ff;
               end
               default: begin
                  // erased node goes to the free head
                  nwr_en = 1'b1; nwr_a = save_ff[AW-1:0]; nwr_d = free_ff;
                  free_in = save_ff;
               end
            endcase
         end
         S_WALK: begin
            // read next link of the walked node
            if (walk_ff < NONE) begin
               nrd_en = 1'b1; nrd_a = walk_ff[AW-1:0];
               state_in = S_WSTEP;
            end else begin
               walk_in = NONE; count_in = '0; head_in = NONE; tail_in = NONE;
               out_v_in = 1'b1; state_in = S_IDLE;
            end
         end
         S_WSTEP: begin
            // free the walked node, then move on
            in_use_in[walk_ff[AW-1:0]] = 1'b0;
            nwr_en = 1'b1; nwr_a = walk_ff[AW-1:0]; nwr_d = free_ff;
            free_in = walk_ff;
            walk_in = nrd_ff;
            state_in = S_WALK;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT; free_ff <= '0; head_ff <= NONE; tail_ff <= NONE;
         count_ff <= '0; walk_ff <= '0; in_use_ff <= '0; out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in; free_ff <= free_in; head_ff <= head_in;
         tail_ff <= tail_in; count_ff <= count_in; walk_ff <= walk_in;
         in_use_ff <= in_use_in; out_v_ff <= out_v_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff <= op_in; idx_ff <= idx_in; elem_ff <= elem_in; save_ff <= save_in;
      out_st_ff <= out_st_in; out_nn_ff <= out_nn_in; out_el_ff <= out_el_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = out_v_ff;
   assign rsp_status       = out_st_ff;
   assign rsp_created_node = out_nn_ff;
   assign rsp_element_out  = out_el_ff;
   assign rsp_node_count   = count_ff;
   assign rsp_first_node   = head_ff;
   assign rsp_last_node    = tail_ff;

endmodule

// ===== bench/pooled_doubly_linked_list_unit_tb.sv =====
// testbench for the pooled doubly linked list unit: scoreboard, stimulus and checks
module pooled_doubly_linked_list_unit_tb
   import pdll_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODES = 64;
   localparam logic [6:0] NO_NODE = 7'd64;
   localparam logic [2:0] OP_LAST = 3'd7;

   typedef struct packed {
      logic [1:0]  status;
      logic [6:0]  created;
      logic [31:0] element;
      logic [6:0]  count;
      logic [6:0]  first;
      logic [6:0]  last;
   } list_word_type;

   // list state mirror and queue of expected response words
   class list_scoreboard;
      logic [6:0]  next_of [NODES];
      logic [6:0]  prev_of [NODES];
      logic [31:0] element_of [NODES];
      bit          allocated [NODES];
      logic [6:0]  free_top, head, tail, count;
      list_word_type expected_words [$];
      int          errors;

      function new();
         for (int i = 0; i < NODES; i++) begin
            next_of[i] = 7'(i + 1);
            prev_of[i] = '0;
            element_of[i] = '0;
            allocated[i] = 0;
         end
         free_top = '0;
         head = NO_NODE;
         tail = NO_NODE;
         count = '0;
         errors = 0;
      endfunction

      // random node that is in the list, or any index if the list is empty
      function logic [6:0] pick_member();
         int members [$];
         for (int i = 0; i < NODES; i++)
            if (allocated[i]) members.push_back(i);
         if (members.size() == 0) return 7'($urandom_range(NODES - 1));
         return 7'(members[$urandom_range(members.size() - 1)]);
      endfunction

      function logic [6:0] grab_node(logic [31:0] e, logic [6:0] nx, logic [6:0] pv);
         logic [6:0] n;
         n = free_top;
         free_top = next_of[n];
         allocated[n] = 1;
         element_of[n] = e;
         next_of[n] = nx;
         prev_of[n] = pv;
         count++;
         return n;
      endfunction

      function void drop_node(logic [6:0] n);
         allocated[n] = 0;
         next_of[n] = free_top;
         free_top = n;
      endfunction

      // apply one accepted request and queue the word it must produce
      function void note_request(logic [2:0] op, logic [6:0] idx, logic [31:0] e);
         list_word_type w;
         logic [6:0] p, n, walk;
         bit full, in_range;
         w = '0;
         w.status = ST_OK;
         w.created = NO_NODE;
         full = (count >= NODES) || (free_top >= NODES);
         in_range = idx < NODES;
         case (op)
            OP_APPEND: begin
               if (full) w.status = ST_FULL;
               else begin
                  w.created = grab_node(e, NO_NODE, tail);
                  if (tail >= NODES) head = w.created;
                  else next_of[tail] = w.created;
                  tail = w.created;
               end
            end
            OP_INSERT: begin
               if (!in_range) w.status = ST_NONODE;
               else if (full) w.status = ST_FULL;
               else if (!allocated[idx]) w.status = ST_NONODE;
               else begin
                  p = prev_of[idx];
                  w.created = grab_node(e, idx, p);
                  if (p < NODES) next_of[p] = w.created;
                  else head = w.created;
                  prev_of[idx] = w.created;
               end
            end
            OP_ERASE: begin
               if (!in_range) w.status = ST_NONODE;
               else if (count == 0) w.status = ST_EMPTY;
               else if (!allocated[idx]) w.status = ST_NONODE;
               else begin
                  p = prev_of[idx];
                  n = next_of[idx];
                  if (p < NODES) next_of[p] = n;
                  else head = n;
                  if (n < NODES) prev_of[n] = p;
                  else tail = p;
                  count--;
                  drop_node(idx);
               end
            end
            OP_CLEAR: begin
               // free from first to last, so the old tail ends on top of the free chain
               walk = head;
               for (int s = 0; s < NODES && walk < NODES; s++) begin
                  n = next_of[walk];
                  drop_node(walk);
                  walk = n;
               end
               count = '0;
               head = NO_NODE;
               tail = NO_NODE;
            end
            OP_READ: begin
               if (!in_range) w.status = ST_NONODE;
               else if (count == 0) w.status = ST_EMPTY;
               else if (!allocated[idx]) w.status = ST_NONODE;
               else w.element = element_of[idx];
            end
            default: ;
         endcase
         w.count = count;
         w.first = head;
         w.last = tail;
         expected_words.push_back(w);
      endfunction

      // compare one response word with the oldest expected one
      function void check_result(list_word_type got);
         list_word_type exp_w;
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word %h", $time, got);
            errors++;
            return;
         end
         exp_w = expected_words.pop_front();
         if (got.status !== exp_w.status) begin
            $display("%0t: status exp %0d got %0d", $time, exp_w.status, got.status);
            errors++;
         end
         if (got.created !== exp_w.created) begin
            $display("%0t: created node exp %0d got %0d", $time, exp_w.created,
                     got.created);
            errors++;
         end
         if (got.element !== exp_w.element) begin
            $display("%0t: element exp %h got %h", $time, exp_w.element, got.element);
            errors++;
         end
         if (got.count !== exp_w.count) begin
            $display("%0t: count exp %0d got %0d", $time, exp_w.count, got.count);
            errors++;
         end
         if (got.first !== exp_w.first) begin
            $display("%0t: first exp %0d got %0d", $time, exp_w.first, got.first);
            errors++;
         end
         if (got.last !== exp_w.last) begin
            $display("%0t: last exp %0d got %0d", $time, exp_w.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [2:0]  req_op = '0;
   logic [6:0]  req_node_index = '0;
   logic [31:0] req_element_in = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [6:0]  rsp_created_node, rsp_node_count, rsp_first_node, rsp_last_node;
   logic [31:0] rsp_element_out;

   list_scoreboard sb = new();
   int idle_pct = 0;

   pooled_doubly_linked_list_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_node_index(req_node_index), .req_element_in(req_element_in),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_created_node(rsp_created_node),
      .rsp_element_out(rsp_element_out), .rsp_node_count(rsp_node_count),
      .rsp_first_node(rsp_first_node), .rsp_last_node(rsp_last_node)
   );

   // clock
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result({rsp_status, rsp_created_node, rsp_element_out, rsp_node_count,
                          rsp_first_node, rsp_last_node});
   end

   // send one request word, with random idle cycles ahead of it
   task automatic send(logic [2:0] op, logic [6:0] idx, logic [31:0] e);
      while (int'($urandom_range(99)) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_op <= op;
      req_node_index <= idx;
      req_element_in <= e;
      do @(posedge clock); while (busy);
      sb.note_request(op, idx, e);
   endtask

   // one random request, mostly well-formed
   task automatic send_random();
      int r;
      logic [6:0] idx;
      r = $urandom_range(99);
      idx = ($urandom_range(9) == 0) ? 7'($urandom) : sb.pick_member();
      if (r < 38) send(OP_APPEND, 7'($urandom), $urandom);
      else if (r < 55) send(OP_INSERT, idx, $urandom);
      else if (r < 72) send(OP_ERASE, idx, $urandom);
      else if (r < 90) send(OP_READ, idx, $urandom);
      else if (r < 93) send(OP_CLEAR, 7'($urandom), $urandom);
      else if (r < 96) send(3'($urandom_range(OP_READ + 1, OP_LAST)), idx, $urandom);
      else send(3'($urandom_range(OP_INSERT, OP_READ)), 7'($urandom_range(NODES, 127)),
                $urandom);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      // directed: empty list, bad indexes, unknown opcodes, extremes of the element
      send(OP_READ, 7'd5, '0);
      send(OP_ERASE, 7'd0, '0);
      send(OP_READ, NO_NODE, '0);
      send(OP_INSERT, NO_NODE, 32'h1);
      send(OP_INSERT, 7'd3, 32'h2);
      send(OP_CLEAR, '0, '0);
      send(OP_APPEND, '0, 32'h0);
      send(OP_APPEND, 7'h7f, 32'hffff_ffff);
      send(OP_INSERT, 7'd0, 32'h5555_aaaa);
      send(OP_READ, 7'd1, '0);
      send(OP_READ, 7'd2, '0);
      send(OP_READ, 7'h7f, '0);
      send(OP_ERASE, 7'd9, '0);
      send(OP_ERASE, 7'd0, '0);
      for (int o = OP_READ + 1; o <= OP_LAST; o++) send(3'(o), 7'd1, 32'hdead_beef);
      send(OP_CLEAR, '0, '0);
      // fill the pool, then hit the full cases
      for (int i = 0; i < NODES; i++) send(OP_APPEND, '0, $urandom);
      send(OP_APPEND, '0, 32'h1234);
      send(OP_INSERT, 7'd10, 32'h1234);
      send(OP_INSERT, NO_NODE, 32'h1234);
      send(OP_READ, 7'd63, '0);
      send(OP_CLEAR, '0, '0);
      // random phases with different sender idling
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 1) ? 57 : (ph == 3) ? 15 : 0;
         for (int i = 0; i < 95; i++) begin
            // occasional append bursts push the list toward full
            if ($urandom_range(40) == 0)
               repeat ($urandom_range(10, 30)) send(OP_APPEND, '0, $urandom);
            else send_random();
         end
      end
      start <= 0;
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.expected_words.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // run limit
   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

endmodule
